[hdl/multichannel_pd_controller_macros.svh]
// -----------------------------------------------------------------------------
// Assertion macros for the multichannel PD controller
// Concurrent assertion shorthands clocked by clk_i and disabled during reset.
// -----------------------------------------------------------------------------
`ifndef MULTICHANNEL_PD_CONTROLLER_MACROS_SVH
`define MULTICHANNEL_PD_CONTROLLER_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define MPDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define MPDC_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[hdl/mpdc_pkg.sv]
// -----------------------------------------------------------------------------
// Multichannel PD controller package
// Fixed field widths, register indexes, reset values and shared types.
// -----------------------------------------------------------------------------
package mpdc_pkg;

  // Fixed field widths.
  localparam int CHAN_W      = 2;
  localparam int SETPOINT_W  = 11;
  localparam int GAIN_W      = 16;
  localparam int DRIVE_W     = 11;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Number of setpoint registers, one per addressable channel.
  localparam int SETPOINT_REGS = 4;

  // Output scaling and clamp.
  localparam int GAIN_SHIFT  = 5;
  localparam int GAIN_SCALE  = 32;
  localparam int DRIVE_LIMIT = 1000;

  // Register reset values.
  localparam logic signed [GAIN_W-1:0] KP_RESET = 16'sd120;
  localparam logic signed [GAIN_W-1:0] KD_RESET = 16'sd300;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT_CH0 = 3'd0,
    CFG_SETPOINT_CH1 = 3'd1,
    CFG_SETPOINT_CH2 = 3'd2,
    CFG_SETPOINT_CH3 = 3'd3,
    CFG_KP           = 3'd4,
    CFG_KD           = 3'd5
  } cfg_idx_e;

  // Register contents handed from the register file to the datapath.
  typedef struct packed {
    logic [SETPOINT_REGS-1:0][SETPOINT_W-1:0] setpoint;
    logic signed [GAIN_W-1:0]                 kp;
    logic signed [GAIN_W-1:0]                 kd;
  } gains_t;

endpackage

[hdl/mpdc_sample_if.sv]
// -----------------------------------------------------------------------------
// Sample channel interface
// Carries one channel number and two differential ADC readings per word.
// -----------------------------------------------------------------------------
interface mpdc_sample_if
  import mpdc_pkg::*;
#(
  parameter int ADC_BITS = 12
);
  logic                valid;
  logic                ready;
  logic [CHAN_W-1:0]   chan;
  logic [ADC_BITS-1:0] sense_pos;
  logic [ADC_BITS-1:0] sense_neg;

  modport source (output valid, output chan, output sense_pos, output sense_neg,
                  input ready);
  modport sink   (input valid, input chan, input sense_pos, input sense_neg,
                  output ready);
endinterface

[hdl/mpdc_drive_if.sv]
// -----------------------------------------------------------------------------
// Drive channel interface
// Carries the channel number and the clamped drive value per word.
// -----------------------------------------------------------------------------
interface mpdc_drive_if
  import mpdc_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [CHAN_W-1:0]         out_chan;
  logic signed [DRIVE_W-1:0] drive;

  modport source (output valid, output out_chan, output drive, input ready);
  modport sink   (input valid, input out_chan, input drive, output ready);
endinterface

[hdl/mpdc_cfg_if.sv]
// -----------------------------------------------------------------------------
// Configuration write interface
// Carries a register index and write data per word.
// -----------------------------------------------------------------------------
interface mpdc_cfg_if
  import mpdc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/mpdc_cfg_regs.sv]
// -----------------------------------------------------------------------------
// Configuration register file
// Holds the four setpoints and the two gains; writes beyond the list are dropped.
// -----------------------------------------------------------------------------
module mpdc_cfg_regs
  import mpdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mpdc_cfg_if.sink    cfg_i,
  output gains_t      gains_o
);

  gains_t gains_q, gains_d;

  // The register file can always take a word.
  assign cfg_i.ready = 1'b1;

  // Decode the register index of a write.
  always_comb begin
    gains_d = gains_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_SETPOINT_CH0: gains_d.setpoint[0] = cfg_i.data[SETPOINT_W-1:0];
        CFG_SETPOINT_CH1: gains_d.setpoint[1] = cfg_i.data[SETPOINT_W-1:0];
        CFG_SETPOINT_CH2: gains_d.setpoint[2] = cfg_i.data[SETPOINT_W-1:0];
        CFG_SETPOINT_CH3: gains_d.setpoint[3] = cfg_i.data[SETPOINT_W-1:0];
        CFG_KP:           gains_d.kp          = cfg_i.data[GAIN_W-1:0];
        CFG_KD:           gains_d.kd          = cfg_i.data[GAIN_W-1:0];
        default:          gains_d             = gains_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.setpoint <= '0;
      gains_q.kp       <= KP_RESET;
      gains_q.kd       <= KD_RESET;
    end else begin
      gains_q <= gains_d;
    end
  end

  assign gains_o = gains_q;

endmodule

[hdl/multichannel_pd_controller.sv]
// -----------------------------------------------------------------------------
// Multichannel PD controller
// PD regulator with per-channel derivative memory, scaling and output clamp.
// -----------------------------------------------------------------------------
// The block takes one sample word per clock while the output side is not
// stalled, and returns one drive word for each, in order. The drive word is
// offered from the last register of the pipeline. The pipeline has an input
// register, a product register fed by the proportional and derivative
// multipliers working side by side, and the result register. The scale by 1/32
// (rounded toward zero) and the clamp to +-1000 sit in front of the result
// register. The stored measurement of a channel is read and updated in the
// same stage, so samples of one channel may follow each other in back-to-back
// cycles. A sample for a channel at or above CHANNELS returns drive zero and
// leaves the stored measurements alone. Configuration writes are taken in any
// cycle and should be made while idle.
// -----------------------------------------------------------------------------
module multichannel_pd_controller
  import mpdc_pkg::*;
#(
  parameter int CHANNELS = 4,
  parameter int ADC_BITS = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mpdc_sample_if.sink   sample_i,
  mpdc_drive_if.source  drive_o,
  mpdc_cfg_if.sink      cfg_i
);

`include "multichannel_pd_controller_macros.svh"

  // Datapath widths.
  localparam int MW   = ADC_BITS + 1;
  localparam int EW   = ((SETPOINT_W > MW) ? SETPOINT_W : MW) + 1;
  localparam int DW   = MW + 1;
  localparam int PW_P = EW + GAIN_W;
  localparam int PW_D = DW + GAIN_W;
  localparam int SW   = ((PW_P > PW_D) ? PW_P : PW_D) + 1;

  gains_t gains;

  // Configuration registers.
  mpdc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .gains_o (gains)
  );

  // Stage handshake: each stage moves when the next is empty or moving.
  logic out_v_q, s1_v_q, s2_v_q;
  logic out_en, s2_en, s1_en;

  assign out_en         = !out_v_q || drive_o.ready;
  assign s2_en          = !s2_v_q || out_en;
  assign s1_en          = !s1_v_q || s2_en;
  assign sample_i.ready = s1_en;

  // Input register.
  logic [CHAN_W-1:0]   s1_chan_q;
  logic [ADC_BITS-1:0] s1_pos_q, s1_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_en) begin
      s1_v_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && sample_i.valid) begin
      s1_chan_q <= sample_i.chan;
      s1_pos_q  <= sample_i.sense_pos;
      s1_neg_q  <= sample_i.sense_neg;
    end
  end

  // Measurement, error and derivative difference.
  logic [CHANNELS-1:0][MW-1:0] prev_q;
  logic signed [MW-1:0]        meas;
  logic signed [MW-1:0]        prev_sel;
  logic signed [SETPOINT_W-1:0] sp_sel;
  logic signed [EW-1:0]        err;
  logic signed [DW-1:0]        diff;
  logic                        chan_ok;
  logic                        s1_move;

  assign meas    = signed'({1'b0, s1_pos_q}) - signed'({1'b0, s1_neg_q});
  assign chan_ok = (int'(s1_chan_q) < CHANNELS);
  assign sp_sel  = signed'(gains.setpoint[s1_chan_q]);
  assign s1_move = s1_v_q && s2_en;

  always_comb begin
    prev_sel = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (int'(s1_chan_q) == i) begin
        prev_sel = signed'(prev_q[i]);
      end
    end
  end

  assign err  = EW'(sp_sel) - EW'(meas);
  assign diff = DW'(prev_sel) - DW'(meas);

  // Stored measurement per channel, updated as the sample leaves stage one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (s1_move && chan_ok) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (int'(s1_chan_q) == i) begin
          prev_q[i] <= meas;
        end
      end
    end
  end

  // Proportional and derivative products.
  logic signed [PW_P-1:0] prod_p_d, prod_p_q;
  logic signed [PW_D-1:0] prod_d_d, prod_d_q;
  logic [CHAN_W-1:0]      s2_chan_q;
  logic                   s2_ok_q;

  assign prod_p_d = PW_P'(err) * PW_P'(gains.kp);
  assign prod_d_d = PW_D'(diff) * PW_D'(gains.kd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_chan_q <= s1_chan_q;
      s2_ok_q   <= chan_ok;
      prod_p_q  <= prod_p_d;
      prod_d_q  <= prod_d_d;
    end
  end

  // Sum, scale toward zero and clamp.
  logic signed [SW-1:0]      sum, sum_adj, quot;
  logic signed [DRIVE_W-1:0] drive_d, drive_q;
  logic [CHAN_W-1:0]         out_chan_q;

  assign sum     = SW'(prod_p_q) + SW'(prod_d_q);
  assign sum_adj = sum[SW-1] ? (sum + SW'(GAIN_SCALE - 1)) : sum;
  assign quot    = sum_adj >>> GAIN_SHIFT;

  always_comb begin
    if (!s2_ok_q) begin
      drive_d = '0;
    end else if (quot > SW'(DRIVE_LIMIT)) begin
      drive_d = DRIVE_W'(DRIVE_LIMIT);
    end else if (quot < -SW'(DRIVE_LIMIT)) begin
      drive_d = -DRIVE_W'(DRIVE_LIMIT);
    end else begin
      drive_d = quot[DRIVE_W-1:0];
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s2_v_q) begin
      out_chan_q <= s2_chan_q;
      drive_q    <= drive_d;
    end
  end

  assign drive_o.valid    = out_v_q;
  assign drive_o.out_chan = out_chan_q;
  assign drive_o.drive    = drive_q;

  // Checks on the pipeline and the clamp.
  `MPDC_ASSERT(a_drive_in_range, out_v_q |-> (drive_q <= DRIVE_W'(DRIVE_LIMIT) && drive_q >= -DRIVE_W'(DRIVE_LIMIT)), "drive word outside the clamp range")
  `MPDC_ASSERT(a_take_fills_s1, (sample_i.valid && sample_i.ready) |=> s1_v_q, "accepted sample lost at stage one")
  `MPDC_ASSERT(a_s2_to_out, (s2_v_q && out_en) |=> out_v_q, "product stage word lost at the result register")
  `MPDC_ASSERT(a_prev_hold, !s1_move |=> $stable(prev_q), "stored measurement changed without a sample moving")

endmodule
